// ===== hdl/sprite_6bit_run_decoder_macros.svh =====
// Assertion macros shared by the run decoder modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SPRITE_6BIT_RUN_DECODER_MACROS_SVH
`define SPRITE_6BIT_RUN_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define S6RD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("s6rd assertion failed");

// Next-cycle implication, disabled while in reset
`define S6RD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("s6rd assertion failed");

`endif

// ===== hdl/s6rd_pkg.sv =====
// Shared types and constants for the 6-bit sprite run decoder.
// No dependencies; the cfg, decode engine, result queue and top files import this package.
package s6rd_pkg;

    localparam int SYM_BITS    = 6;
    localparam int WORD_BITS   = 16;
    localparam int RES_BITS    = 21;
    localparam int CNT_BITS    = 5;
    localparam int LIT_BITS    = 6;
    localparam int COL_BITS    = 13;
    localparam int ROW_BITS    = 12;
    localparam int WIDTH_BITS  = 12;
    localparam int STRIDE_BITS = 13;
    localparam int PROD_BITS   = 25;
    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;
    localparam int WORDQ_DEPTH = 2;
    localparam int RESQ_DEPTH  = 4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STRIDE = 2'd2;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 12'd1;
    localparam logic [ROW_BITS-1:0]    HEIGHT_RST = 12'd1;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RST = 13'd4;

    // Symbol decode phase
    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_COUNT = 2'd1,
        PH_LIT   = 2'd2
    } t_phase;

    // Effective configuration seen by the decode engine
    typedef struct packed {
        logic [WIDTH_BITS-1:0] width;
        logic [ROW_BITS-1:0]   height;
        logic                  restart;
    } t_cfg;

    // Result fields other than the address
    typedef struct packed {
        logic [SYM_BITS-1:0] value;
        logic                valid;
        logic                done;
        logic                ovf;
    } t_flags;

    // Engine to result queue control
    typedef struct packed {
        logic res_valid;
        logic word_end;
    } t_res_ctl;

endpackage

// ===== hdl/s6rd_fifo.sv =====
// Small synchronous FIFO built from flip-flops, combinational read port.
// Depends on nothing; used for the word queue and the result queue.
module s6rd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entry data
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/s6rd_cfg.sv =====
// Configuration registers behind the APB-style port, and the buffer bound.
// Depends on s6rd_pkg.
module s6rd_cfg
    import s6rd_pkg::*;
#(
    parameter int ADDR_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [PDATA_BITS-1:0]  pwdata,
    output logic [PDATA_BITS-1:0]  prdata,
    output logic                   pready,
    output t_cfg                   o_cfg,
    output logic [ADDR_BITS-1:0]   o_bound
);

    localparam int CW = (ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS;
    localparam logic [CW-1:0] ADDR_MAX = CW'({ADDR_BITS{1'b1}});

    logic [WIDTH_BITS-1:0]  r_width;
    logic [ROW_BITS-1:0]    r_height;
    logic [STRIDE_BITS-1:0] r_stride;
    logic [ADDR_BITS-1:0]   r_bound;
    logic [1:0]             reg_idx;
    logic                   wr;
    logic [ROW_BITS-1:0]    height_eff;
    logic [PROD_BITS-1:0]   prod;
    logic [CW-1:0]          prod_x;
    logic [CW-1:0]          bound_x;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr      = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_stride <= STRIDE_RST;
        end else if (wr) begin
            unique case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[WIDTH_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[ROW_BITS-1:0];
                REG_STRIDE: r_stride <= pwdata[STRIDE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = PDATA_BITS'(r_width);
            REG_HEIGHT: prdata = PDATA_BITS'(r_height);
            REG_STRIDE: prdata = PDATA_BITS'(r_stride);
            default:    prdata = '0;
        endcase
    end

    // Zero width or height acts as one
    assign height_eff      = (r_height == '0) ? ROW_BITS'(1) : r_height;
    assign o_cfg.height    = height_eff;
    assign o_cfg.width     = (r_width == '0) ? WIDTH_BITS'(1) : r_width;
    assign o_cfg.restart   = wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                                    reg_idx == REG_STRIDE);

    // Bound is stride times height, clamped to the all-ones address
    assign prod    = PROD_BITS'(r_stride) * PROD_BITS'(height_eff);
    assign prod_x  = CW'(prod);
    assign bound_x = (prod_x > ADDR_MAX) ? ADDR_MAX : prod_x;

    always_ff @(posedge i_clk) begin
        r_bound <= bound_x[ADDR_BITS-1:0];
    end

    assign o_bound = r_bound;

endmodule

// ===== hdl/s6rd_back.sv =====
// Decode engine: bit reservoir, symbol phase machine, address and row tracking.
// Depends on s6rd_pkg and the assertion macro header.
`include "sprite_6bit_run_decoder_macros.svh"
module s6rd_back
    import s6rd_pkg::*;
#(
    parameter int ADDR_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic [ADDR_BITS-1:0]   i_bound,
    input  logic [WORD_BITS-1:0]   i_word,
    input  logic                   i_word_avail,
    output logic                   o_pop,
    input  logic                   i_ready,
    output t_res_ctl               o_ctl,
    output logic [ADDR_BITS-1:0]   o_addr,
    output t_flags                 o_flags
);

    localparam int INC_BITS = 7;

    t_phase               r_phase, n_phase;
    logic [RES_BITS-1:0]  r_res, n_res;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [LIT_BITS-1:0]  r_lit, n_lit;
    logic [COL_BITS-1:0]  r_col, n_col;
    logic [ROW_BITS-1:0]  r_rows, n_rows;
    logic [ADDR_BITS-1:0] r_dest, n_dest;

    logic [SYM_BITS-1:0]  sym;
    logic                 step;
    logic                 col_ge;
    logic                 last_row;
    logic [LIT_BITS-1:0]  lit_dec;
    logic                 grp_end;
    logic                 row_end;
    logic                 done;
    logic [1:0]           pad;
    logic [INC_BITS-1:0]  inc;
    logic [ADDR_BITS:0]   dest_sum;
    logic [ADDR_BITS-1:0] dest_sat;
    logic [RES_BITS-1:0]  base_res;
    logic [CNT_BITS-1:0]  base_cnt;

    // Shared decode conditions
    assign sym      = r_res[SYM_BITS-1:0];
    assign step     = (r_cnt >= CNT_BITS'(SYM_BITS)) && i_ready && !i_cfg.restart;
    assign col_ge   = (r_col >= COL_BITS'(i_cfg.width));
    assign last_row = ((r_rows + 1'b1) == i_cfg.height);
    assign lit_dec  = r_lit - 1'b1;
    assign pad      = 2'd0 - r_col[1:0];

    always_comb begin
        unique case (r_phase)
            PH_COUNT: grp_end = (sym == '0);
            PH_LIT:   grp_end = (lit_dec == '0);
            default:  grp_end = 1'b0;
        endcase
    end

    assign row_end = grp_end && col_ge;
    assign done    = row_end && last_row;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_cfg.restart) begin
            n_phase = PH_SKIP;
        end else if (step) begin
            if (done) begin
                n_phase = PH_SKIP;
            end else begin
                unique case (r_phase)
                    PH_COUNT: n_phase = (sym != '0) ? PH_LIT : PH_SKIP;
                    PH_LIT:   n_phase = (lit_dec == '0) ? PH_SKIP : PH_LIT;
                    default:  n_phase = PH_COUNT;
                endcase
            end
        end
    end

    // Saturating destination advance
    always_comb begin
        unique case (r_phase)
            PH_COUNT: inc = row_end ? INC_BITS'(pad) : '0;
            PH_LIT:   inc = INC_BITS'(1) + (row_end ? INC_BITS'(pad) : '0);
            default:  inc = INC_BITS'(sym);
        endcase
    end

    assign dest_sum = {1'b0, r_dest} + (ADDR_BITS + 1)'(inc);
    assign dest_sat = dest_sum[ADDR_BITS] ? '1 : dest_sum[ADDR_BITS-1:0];

    // Result outputs
    always_comb begin
        o_ctl.res_valid = 1'b0;
        o_ctl.word_end  = step && (done || (base_cnt < CNT_BITS'(SYM_BITS)));
        o_addr          = '0;
        o_flags         = '0;
        if (step) begin
            unique case (r_phase)
                PH_COUNT: begin
                    o_ctl.res_valid = done;
                    o_flags.done    = done;
                end
                PH_LIT: begin
                    o_ctl.res_valid = 1'b1;
                    o_addr          = r_dest;
                    o_flags.value   = sym;
                    o_flags.valid   = (r_dest < i_bound);
                    o_flags.ovf     = !(r_dest < i_bound);
                    o_flags.done    = done;
                end
                default: ;
            endcase
        end
    end

    // Reservoir: drop the consumed symbol, then refill from the word queue
    always_comb begin
        if (step) begin
            base_res = done ? '0 : (r_res >> SYM_BITS);
            base_cnt = done ? '0 : (r_cnt - CNT_BITS'(SYM_BITS));
        end else begin
            base_res = r_res;
            base_cnt = r_cnt;
        end
        o_pop = (base_cnt < CNT_BITS'(SYM_BITS)) && i_word_avail && !i_cfg.restart;
        n_res = o_pop ? (base_res | (RES_BITS'(i_word) << base_cnt)) : base_res;
        n_cnt = o_pop ? (base_cnt + CNT_BITS'(WORD_BITS)) : base_cnt;
    end

    // Column, row, literal and address tracking
    always_comb begin
        n_lit  = r_lit;
        n_col  = r_col;
        n_rows = r_rows;
        n_dest = r_dest;
        if (step) begin
            n_dest = dest_sat;
            unique case (r_phase)
                PH_COUNT: begin
                    n_lit = sym;
                    n_col = r_col + COL_BITS'(sym);
                end
                PH_LIT: begin
                    n_lit = lit_dec;
                end
                default: begin
                    n_col = r_col + COL_BITS'(sym);
                end
            endcase
            if (row_end) begin
                n_col  = '0;
                n_rows = r_rows + 1'b1;
            end
            if (done) begin
                n_lit  = '0;
                n_col  = '0;
                n_rows = '0;
                n_dest = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_phase <= PH_SKIP;
            r_res   <= '0;
            r_cnt   <= '0;
            r_lit   <= '0;
            r_col   <= '0;
            r_rows  <= '0;
            r_dest  <= '0;
        end else begin
            r_phase <= n_phase;
            r_res   <= n_res;
            r_cnt   <= n_cnt;
            r_lit   <= n_lit;
            r_col   <= n_col;
            r_rows  <= n_rows;
            r_dest  <= n_dest;
        end
    end

    `S6RD_ASSERT_IMPL(a_lit_nonzero, r_phase == PH_LIT, r_lit != '0)
    `S6RD_ASSERT_IMPL(a_res_clean, 1'b1, (r_res >> r_cnt) == '0)
    `S6RD_ASSERT_NEXT(a_done_clears, step && done,
                      r_col == '0 && r_dest == '0 && r_phase == PH_SKIP)

endmodule

// ===== hdl/s6rd_resq.sv =====
// Result queue: holds one result back until the next one or the end of its
// word is known, so the last flag is exact. Depends on s6rd_pkg, s6rd_fifo and the macro header.
`include "sprite_6bit_run_decoder_macros.svh"
module s6rd_resq
    import s6rd_pkg::*;
#(
    parameter int ADDR_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_res_ctl               i_ctl,
    input  logic [ADDR_BITS-1:0]   i_addr,
    input  t_flags                 i_flags,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ADDR_BITS-1:0]   o_pixel_address,
    output t_flags                 o_flags,
    output logic                   o_last
);

    localparam int FW = $bits(t_flags);
    localparam int DW = ADDR_BITS + FW + 1;
    localparam int QC = $clog2(RESQ_DEPTH + 1);

    logic                 r_pend_valid, n_pend_valid;
    logic                 r_pend_final, n_pend_final;
    logic [ADDR_BITS-1:0] r_pend_addr, n_pend_addr;
    t_flags               r_pend_flags, n_pend_flags;

    logic                 push;
    logic [DW-1:0]        push_data;
    logic [DW-1:0]        q_data;
    logic                 q_empty, q_full, q_pop;
    logic [QC-1:0]        q_count;

    // Room for one more push even without a pop this cycle
    assign o_ready   = (q_count <= QC'(RESQ_DEPTH - 2));
    assign push_data = {r_pend_addr, r_pend_flags, r_pend_final};

    // Hold the newest result; release it once its successor or word end is seen
    always_comb begin
        push         = 1'b0;
        n_pend_valid = r_pend_valid;
        n_pend_final = r_pend_final;
        n_pend_addr  = r_pend_addr;
        n_pend_flags = r_pend_flags;
        if (i_ctl.res_valid) begin
            push         = r_pend_valid;
            n_pend_valid = 1'b1;
            n_pend_final = i_ctl.word_end;
            n_pend_addr  = i_addr;
            n_pend_flags = i_flags;
        end else if (r_pend_valid && r_pend_final && !q_full) begin
            push         = 1'b1;
            n_pend_valid = 1'b0;
            n_pend_final = 1'b0;
        end else if (i_ctl.word_end && r_pend_valid) begin
            n_pend_final = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_final <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_final <= n_pend_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr  <= n_pend_addr;
        r_pend_flags <= n_pend_flags;
    end

    s6rd_fifo #(
        .WIDTH (DW),
        .DEPTH (RESQ_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    // Drive the result channel from the queue head
    assign o_valid         = !q_empty;
    assign q_pop           = o_valid && !i_stall;
    assign o_pixel_address = q_data[DW-1 -: ADDR_BITS];
    assign o_flags         = q_data[FW:1];
    assign o_last          = q_data[0];

    `S6RD_ASSERT_IMPL(a_no_overrun, push, !q_full)
    `S6RD_ASSERT_IMPL(a_issue_ready, i_ctl.res_valid || i_ctl.word_end, o_ready)
    `S6RD_ASSERT_IMPL(a_done_last, o_valid && o_flags.done, o_last)

endmodule

// ===== hdl/sprite_6bit_run_decoder.sv =====
// Six-bit sprite run decoder, top level: word queue, decode engine, result queue.
// Throughput: one 6-bit symbol per cycle in the decode engine while the result queue
// is ready and bits are held; a 16-bit word gives two or three 6-bit symbols.
// A word passes through the word queue, the reservoir, the held-back result and the
// result queue; a result waits until its successor or its word end is known.
// Reset (synchronous, active low) sets width 1, height 1, stride 4 and clears
// all decode state and queues; a register write restarts the image.
module sprite_6bit_run_decoder
    import s6rd_pkg::*;
#(
    parameter int ADDR_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // compressed word channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [WORD_BITS-1:0]   i_data_word,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ADDR_BITS-1:0]   o_pixel_address,
    output logic [SYM_BITS-1:0]    o_pixel_value,
    output logic                   o_pixel_valid,
    output logic                   o_image_done,
    output logic                   o_overflow,
    output logic                   o_last,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [PDATA_BITS-1:0]  pwdata,
    output logic [PDATA_BITS-1:0]  prdata,
    output logic                   pready
);

    localparam int WQC = $clog2(WORDQ_DEPTH + 1);

    t_cfg                 cfg;
    logic [ADDR_BITS-1:0] bound;
    logic [WORD_BITS-1:0] wq_data;
    logic                 wq_empty, wq_full, wq_pop;
    logic [WQC-1:0]       wq_count;
    logic                 res_ready;
    t_res_ctl             res_ctl;
    logic [ADDR_BITS-1:0] res_addr;
    t_flags               res_flags;
    t_flags               out_flags;

    s6rd_cfg #(
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_bound (bound)
    );

    // Front: accept words into a short queue; hold off while in reset
    assign o_stall = wq_full || !i_rst_n;

    s6rd_fifo #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDQ_DEPTH)
    ) u_wordq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !wq_full),
        .i_data  (i_data_word),
        .i_pop   (wq_pop),
        .o_data  (wq_data),
        .o_empty (wq_empty),
        .o_full  (wq_full),
        .o_count (wq_count)
    );

    // Back: symbol decode
    s6rd_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_bound      (bound),
        .i_word       (wq_data),
        .i_word_avail (!wq_empty && (wq_count != '0)),
        .o_pop        (wq_pop),
        .i_ready      (res_ready),
        .o_ctl        (res_ctl),
        .o_addr       (res_addr),
        .o_flags      (res_flags)
    );

    s6rd_resq #(
        .ADDR_BITS (ADDR_BITS)
    ) u_resq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (res_ctl),
        .i_addr          (res_addr),
        .i_flags         (res_flags),
        .o_ready         (res_ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_address (o_pixel_address),
        .o_flags         (out_flags),
        .o_last          (o_last)
    );

    assign o_pixel_value = out_flags.value;
    assign o_pixel_valid = out_flags.valid;
    assign o_image_done  = out_flags.done;
    assign o_overflow    = out_flags.ovf;

endmodule
